>>> sv/qph_pkg.sv
// shared constants, codes and control types of the quadratic probe hash table
package qph_pkg;

    localparam int DEF_TABLE_SIZE = 10;
    localparam int DEF_KEY_WIDTH  = 16;

    localparam int KEY_IN_W = 16;
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int PROBE_W  = 7;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_LIMIT     = 3'd3,
        ST_INVALID   = 3'd4,
        ST_EXHAUSTED = 3'd5
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    typedef struct packed {
        logic capture;
        logic base;
        logic probe;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic probe_done;
    } sts_t;

endpackage

>>> sv/qph_ram.sv
// generic single write port ram with registered read
module qph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> sv/qph_dp.sv
// datapath: key capture, slot hashing, probe address walk, slot store and result registers
module qph_dp #(
    parameter int TABLE_SIZE = qph_pkg::DEF_TABLE_SIZE,
    parameter int KEY_WIDTH  = qph_pkg::DEF_KEY_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [qph_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           in_opcode,
    input  logic [qph_pkg::KEY_IN_W-1:0]   in_key,
    input  qph_pkg::cmd_t                  cmd,
    output qph_pkg::sts_t                  sts,
    output logic [qph_pkg::STATUS_W-1:0]   out_status,
    output logic [qph_pkg::SLOT_W-1:0]     out_slot_index,
    output logic [qph_pkg::PROBE_W-1:0]    out_probe_count
);

    localparam int ADDR_W   = $clog2(TABLE_SIZE);
    localparam int AX_W     = ADDR_W + 1;
    localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
    localparam int KIN_W    = qph_pkg::KEY_IN_W;
    localparam int KEY_USED = (KEY_WIDTH < KIN_W) ? KEY_WIDTH : KIN_W;
    localparam int SHIFT    = KIN_W + 7;
    localparam int MULT_W   = SHIFT;
    localparam int PROD_W   = KIN_W + MULT_W;
    localparam longint MULT_VAL = (longint'(1) << SHIFT) / TABLE_SIZE + 1;
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_VAL);
    localparam logic [KIN_W-1:0] KEY_MASK = KIN_W'((longint'(1) << KEY_USED) - 1);
    localparam logic [KIN_W-1:0] SIZE_K = KIN_W'(TABLE_SIZE);
    localparam logic [AX_W-1:0] SIZE_X = AX_W'(TABLE_SIZE);
    localparam logic [ADDR_W-1:0] OFF1 = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] DELTA1 = ADDR_W'(3 % TABLE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_SIZE - 1);

    logic [qph_pkg::CFG_W-1:0] max_entries_reg;
    logic [CNT_W-1:0]          entry_count_reg;
    logic [TABLE_SIZE-1:0]     valid_reg;
    logic                      op_reg;
    logic [KIN_W-1:0]          key_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [ADDR_W-1:0]         base_reg;
    logic [ADDR_W-1:0]         off_reg;
    logic [ADDR_W-1:0]         delta_reg;
    logic [ADDR_W-1:0]         idx_reg;
    logic [ADDR_W-1:0]         addr_q_reg;
    logic                      vld_q_reg;
    qph_pkg::status_t          res_status_reg;
    logic [ADDR_W-1:0]         res_slot_reg;
    logic [qph_pkg::PROBE_W-1:0] res_probes_reg;
    qph_pkg::status_t          out_status_reg;
    logic [qph_pkg::SLOT_W-1:0]  out_slot_reg;
    logic [qph_pkg::PROBE_W-1:0] out_probes_reg;

    logic [KIN_W-1:0]     in_key_m;
    logic                 key_zero;
    logic                 at_limit;
    logic [KIN_W-1:0]     quot;
    logic [31:0]          quot_n;
    logic [KIN_W-1:0]     rem;
    logic [KIN_W-1:0]     rem_fix;
    logic [ADDR_W-1:0]    base_c;
    logic [AX_W-1:0]      addr_sum;
    logic [AX_W-1:0]      addr_red;
    logic [AX_W-1:0]      off_sum;
    logic [AX_W-1:0]      off_red;
    logic [AX_W-1:0]      delta_sum;
    logic [AX_W-1:0]      delta_red;
    logic [ADDR_W-1:0]    rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;
    logic [KEY_WIDTH-1:0] held;
    logic [KEY_WIDTH-1:0] key_kw;
    logic                 is_insert;
    logic                 hit_empty;
    logic                 hit_match;
    logic                 last_probe;
    logic                 done;
    logic                 wr_en;
    logic [qph_pkg::PROBE_W-1:0] probes_now;

    // request checks on the incoming beat
    assign in_key_m = in_key & KEY_MASK;
    assign key_zero = (in_key_m == '0);
    assign at_limit = (qph_pkg::opcode_t'(in_opcode) == qph_pkg::OP_INSERT) &&
                      (qph_pkg::CFG_W'(entry_count_reg) >= max_entries_reg);
    assign sts.reject = key_zero || at_limit;

    // key mod table size by reciprocal multiply
    assign quot    = prod_reg[SHIFT +: KIN_W];
    assign quot_n  = 32'(quot) * 32'(TABLE_SIZE);
    assign rem     = key_reg - quot_n[KIN_W-1:0];
    assign rem_fix = (rem >= SIZE_K) ? (rem - SIZE_K) : rem;
    assign base_c  = rem_fix[ADDR_W-1:0];

    // incremental quadratic offsets
    assign addr_sum  = {1'b0, base_reg} + {1'b0, off_reg};
    assign addr_red  = (addr_sum >= SIZE_X) ? (addr_sum - SIZE_X) : addr_sum;
    assign off_sum   = {1'b0, off_reg} + {1'b0, delta_reg};
    assign off_red   = (off_sum >= SIZE_X) ? (off_sum - SIZE_X) : off_sum;
    assign delta_sum = {1'b0, delta_reg} + AX_W'(2);
    assign delta_red = (delta_sum >= SIZE_X) ? (delta_sum - SIZE_X) : delta_sum;
    assign rd_addr   = cmd.base ? base_c : addr_red[ADDR_W-1:0];

    // evaluate the slot read in the previous cycle
    assign key_kw     = KEY_WIDTH'(key_reg);
    assign held       = vld_q_reg ? rd_data : '0;
    assign is_insert  = (qph_pkg::opcode_t'(op_reg) == qph_pkg::OP_INSERT);
    assign hit_empty  = (held == '0);
    assign hit_match  = (held == key_kw);
    assign last_probe = (idx_reg == LAST_IDX);
    assign done       = is_insert ? (hit_empty || last_probe)
                                  : (hit_empty || hit_match || last_probe);
    assign sts.probe_done = done;
    assign wr_en      = cmd.probe && is_insert && hit_empty;
    assign probes_now = qph_pkg::PROBE_W'(idx_reg) + qph_pkg::PROBE_W'(1);

    qph_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_SIZE),
        .ADDR_W(ADDR_W)
    ) u_slots (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(addr_q_reg),
        .wdata(key_kw),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= qph_pkg::MAX_ENTRIES_RST;
            entry_count_reg <= '0;
            valid_reg       <= '0;
        end else begin
            if (cfg_we) begin
                max_entries_reg <= cfg_wdata;
            end
            if (wr_en) begin
                valid_reg[addr_q_reg] <= 1'b1;
                entry_count_reg       <= entry_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= PROD_W'(key_reg) * PROD_W'(MULT);
        addr_q_reg <= rd_addr;
        vld_q_reg  <= valid_reg[rd_addr];
        if (cmd.capture) begin
            op_reg         <= in_opcode;
            key_reg        <= in_key_m;
            res_status_reg <= key_zero ? qph_pkg::ST_INVALID : qph_pkg::ST_LIMIT;
            res_slot_reg   <= '0;
            res_probes_reg <= '0;
        end
        if (cmd.base) begin
            base_reg  <= base_c;
            off_reg   <= OFF1;
            delta_reg <= DELTA1;
            idx_reg   <= '0;
        end
        if (cmd.probe) begin
            off_reg   <= off_red[ADDR_W-1:0];
            delta_reg <= delta_red[ADDR_W-1:0];
            if (done) begin
                res_probes_reg <= probes_now;
                priority if (is_insert && hit_empty) begin
                    res_status_reg <= qph_pkg::ST_INSERTED;
                    res_slot_reg   <= addr_q_reg;
                end else if (!is_insert && hit_match) begin
                    res_status_reg <= qph_pkg::ST_FOUND;
                    res_slot_reg   <= addr_q_reg;
                end else if (!is_insert && hit_empty) begin
                    res_status_reg <= qph_pkg::ST_NOT_FOUND;
                    res_slot_reg   <= '0;
                end else begin
                    res_status_reg <= qph_pkg::ST_EXHAUSTED;
                    res_slot_reg   <= '0;
                end
            end else begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
        end
        if (cmd.emit) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= qph_pkg::SLOT_W'(res_slot_reg);
            out_probes_reg <= res_probes_reg;
        end
    end

    assign out_status      = out_status_reg;
    assign out_slot_index  = out_slot_reg;
    assign out_probe_count = out_probes_reg;

endmodule

>>> sv/qph_ctrl.sv
// controller: request sequencing and handshakes of both channels
module qph_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output qph_pkg::cmd_t cmd,
    input  qph_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_BASE,
        S_PROBE,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:  cmd.capture = s_tvalid;
            S_MUL:   cmd = '0;
            S_BASE:  cmd.base = 1'b1;
            S_PROBE: cmd.probe = 1'b1;
            S_EMIT:  cmd.emit = out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= sts.reject ? S_EMIT : S_MUL;
                    end
                end
                S_MUL:   state_reg <= S_BASE;
                S_BASE:  state_reg <= S_PROBE;
                S_PROBE: begin
                    if (sts.probe_done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/quadratic_probe_hash_table.sv
// quadratic probe hash table top level
// rejected requests (zero key or load limit): no probing, the result goes straight to the emit state
// other requests: multiply, base, probe loop and emit, p = probes taken (1 to TABLE_SIZE)
// one slot read per cycle through the registered-read slot ram sets the probe loop
// next beat is taken once the result is registered; a waiting result does not block it
// synchronous active-low reset empties all slots, clears the entry count, load limit 5
module quadratic_probe_hash_table #(
    parameter int TABLE_SIZE = qph_pkg::DEF_TABLE_SIZE,
    parameter int KEY_WIDTH  = qph_pkg::DEF_KEY_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [qph_pkg::CFG_W-1:0]         cfg_wdata,   // max_entries
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [qph_pkg::IN_DATA_W-1:0]     s_tdata,     // key
    input  logic [0:0]                        s_tuser,     // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qph_pkg::OUT_DATA_W-1:0]    m_tdata      // status, slot_index, probe_count
);

    qph_pkg::cmd_t cmd;
    qph_pkg::sts_t sts;
    logic [qph_pkg::STATUS_W-1:0] out_status;
    logic [qph_pkg::SLOT_W-1:0]   out_slot_index;
    logic [qph_pkg::PROBE_W-1:0]  out_probe_count;

    qph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    qph_dp #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_opcode      (s_tuser[0]),
        .in_key         (s_tdata[qph_pkg::KEY_IN_W-1:0]),
        .cmd            (cmd),
        .sts            (sts),
        .out_status     (out_status),
        .out_slot_index (out_slot_index),
        .out_probe_count(out_probe_count)
    );

    assign m_tdata = {out_probe_count, out_slot_index, out_status};

endmodule

>>> tb/sv/qph_result_checker.sv
// scoreboard for the quadratic probe hash table: mirrors the slots, predicts and checks each result
module qph_result_checker
    import qph_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot_index;
        logic [PROBE_W-1:0]  probe_count;
    } lookup_result_t;

    logic [31:0]      slot_keys [TABLE_SIZE];
    int               stored_keys;
    logic [CFG_W-1:0] load_limit;
    lookup_result_t   lookup_q [$];
    int               mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // walks the probe sequence and updates the mirrored slots on an insert
    function automatic lookup_result_t hash_lookup(opcode_t op, logic [KEY_IN_W-1:0] key_in);
        lookup_result_t res;
        logic [31:0]    key;
        int             idx;
        bit             done;
        res.status      = ST_EXHAUSTED;
        res.slot_index  = '0;
        res.probe_count = PROBE_W'(TABLE_SIZE);
        key  = 32'(((64'd1 << KEY_WIDTH) - 64'd1) & 64'(key_in));
        done = 1'b0;
        if (key == 32'd0) begin
            res.status      = ST_INVALID;
            res.probe_count = '0;
        end else if (op == OP_INSERT && stored_keys >= int'(load_limit)) begin
            res.status      = ST_LIMIT;
            res.probe_count = '0;
        end else begin
            for (int i = 0; i < TABLE_SIZE && !done; i++) begin
                idx = int'((key % TABLE_SIZE + (i * i) % TABLE_SIZE) % TABLE_SIZE);
                if (op == OP_INSERT) begin
                    if (slot_keys[idx] == 32'd0) begin
                        slot_keys[idx] = key;
                        stored_keys++;
                        res.status      = ST_INSERTED;
                        res.slot_index  = SLOT_W'(idx);
                        res.probe_count = PROBE_W'(i + 1);
                        done = 1'b1;
                    end
                end else if (slot_keys[idx] == key) begin
                    res.status      = ST_FOUND;
                    res.slot_index  = SLOT_W'(idx);
                    res.probe_count = PROBE_W'(i + 1);
                    done = 1'b1;
                end else if (slot_keys[idx] == 32'd0) begin
                    res.status      = ST_NOT_FOUND;
                    res.probe_count = PROBE_W'(i + 1);
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic check_result(logic [OUT_DATA_W-1:0] beat);
        lookup_result_t want;
        logic [STATUS_W-1:0] got_status;
        logic [SLOT_W-1:0]   got_slot;
        logic [PROBE_W-1:0]  got_probes;
        got_status = beat[STATUS_W-1:0];
        got_slot   = beat[STATUS_W +: SLOT_W];
        got_probes = beat[STATUS_W+SLOT_W +: PROBE_W];
        if (lookup_q.size() == 0) begin
            report_mismatch($sformatf("result beat 0x%04h with no request waiting", beat));
            return;
        end
        want = lookup_q.pop_front();
        if (got_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
        if (got_slot !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d", got_slot, want.slot_index));
        if (got_probes !== want.probe_count)
            report_mismatch($sformatf("probe_count %0d, want %0d", got_probes,
                                      want.probe_count));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < TABLE_SIZE; s++)
                slot_keys[s] = '0;
            stored_keys = 0;
            load_limit  = MAX_ENTRIES_RST;
            lookup_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (cfg_we)
                load_limit = cfg_wdata;
            if (s_tvalid && s_tready)
                lookup_q.push_back(hash_lookup(opcode_t'(s_tuser[0]), s_tdata));
        end
        pending = lookup_q.size();
    end

endmodule

>>> tb/sv/tb_quadratic_probe_hash_table.sv
// testbench top for the quadratic probe hash table: stimulus, result stalls and verdict
module tb_quadratic_probe_hash_table;
    import qph_pkg::*;

    localparam int LIMIT_TIME       = 4_000_000;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int GAP_MAX          = 17;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending;

    int                  send_gap_max  = GAP_MAX;
    int                  ready_gap_max = GAP_MAX;
    logic [KEY_IN_W-1:0] key_pool [$];

    quadratic_probe_hash_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    qph_result_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_request(opcode_t op, logic [KEY_IN_W-1:0] key);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (op == OP_INSERT && key != '0)
            key_pool.push_back(key);
    endtask

    // drain every outstanding result before touching the load limit
    task automatic set_load_limit(logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_IN_W-1:0] random_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return '0;
        if (pick < 40 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (pick < 55)
            return KEY_IN_W'($urandom_range(1, 60));
        return KEY_IN_W'($urandom_range(0, 65535));
    endfunction

    // result side stalls
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = $urandom_range(0, ready_gap_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("tb_quadratic_probe_hash_table NOT OK");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] limits [6];
        limits    = '{7'd8, 7'd0, 7'd127, 7'd10, 7'd64, 7'd1};
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // zero keys, empty table, duplicates, load limit at reset value
        send_request(OP_INSERT, 16'h0000);
        send_request(OP_SEARCH, 16'h0000);
        send_request(OP_SEARCH, 16'd7);
        send_request(OP_INSERT, 16'hFFFF);
        send_request(OP_INSERT, 16'd1);
        send_request(OP_INSERT, 16'd1);
        send_request(OP_SEARCH, 16'd1);
        send_request(OP_SEARCH, 16'hFFFF);
        send_request(OP_SEARCH, 16'd11);
        send_request(OP_INSERT, 16'd11);
        send_request(OP_INSERT, 16'd21);
        send_request(OP_INSERT, 16'd31);
        send_request(OP_SEARCH, 16'd31);
        set_load_limit(7'd0);
        send_request(OP_INSERT, 16'd2);
        send_request(OP_SEARCH, 16'd21);
        // limit above table size, then fill one probe chain until it runs out
        set_load_limit(7'd64);
        send_request(OP_INSERT, 16'd41);
        send_request(OP_INSERT, 16'd51);
        send_request(OP_SEARCH, 16'd61);
        send_request(OP_SEARCH, 16'd41);

        for (int p = 0; p < 6; p++) begin
            send_gap_max  = (p % 2 == 0) ? GAP_MAX : 0;
            ready_gap_max = (p % 3 == 2) ? 0 : GAP_MAX;
            set_load_limit(limits[p]);
            repeat (RANDOM_PER_PHASE)
                send_request(opcode_t'($urandom_range(0, 1)), random_key());
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("tb_quadratic_probe_hash_table OK");
        else
            $display("tb_quadratic_probe_hash_table NOT OK");
        $finish;
    end

endmodule
